### hw/rtl/dqs_pkg.sv
// Shared types and constants for the deque with search.
package dqs_pkg;

  localparam int DATA_W        = 32;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_COUNT      = 3'd4,
    KIND_SEARCH     = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_RUN    = 1'b0,
    ST_REDUCE = 1'b1
  } state_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic search;
  } cell_ctrl_t;

endpackage

### hw/rtl/dqs_if.sv
// Handshake interfaces for the operation channel and the result channel.
interface dqs_in_if;
  logic                             valid;
  logic                             ready;
  logic [dqs_pkg::KIND_W-1:0]       kind;
  logic signed [dqs_pkg::DATA_W-1:0] data_value;

  modport source (output valid, output kind, output data_value, input ready);
  modport sink   (input valid, input kind, input data_value, output ready);
endinterface

interface dqs_out_if #(parameter int CNT_W = 5);
  logic                              valid;
  logic                              ready;
  logic signed [dqs_pkg::DATA_W-1:0] popped_value;
  logic [CNT_W-1:0]                  entry_count;
  logic                              found;
  logic [dqs_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output popped_value, output entry_count, output found,
                  output status, input ready);
  modport sink   (input valid, input popped_value, input entry_count, input found,
                  input status, output ready);
endinterface

### hw/rtl/dqs_cell.sv
// One storage cell of the shifting deque chain.
module dqs_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  dqs_pkg::cell_ctrl_t        ctrl,
  input  logic [dqs_pkg::DATA_W-1:0] data_value,
  input  logic [dqs_pkg::DATA_W-1:0] left_value,
  input  logic                       left_valid,
  input  logic [dqs_pkg::DATA_W-1:0] right_value,
  input  logic                       right_valid,
  output logic [dqs_pkg::DATA_W-1:0] value,
  output logic                       valid,
  output logic                       hit,
  output logic [dqs_pkg::DATA_W-1:0] pick
);
  import dqs_pkg::*;

  logic is_tail;
  logic is_free_slot;

  // The last held cell has an empty right neighbour; the first free one a full left neighbour.
  assign is_tail      = valid && !right_valid;
  assign is_free_slot = !valid && left_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.push_front) begin
      valid <= left_valid;
    end else if (ctrl.push_back) begin
      valid <= valid || left_valid;
    end else if (ctrl.pop_front) begin
      valid <= right_valid;
    end else if (ctrl.pop_back) begin
      valid <= valid && right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      value <= left_value;
    end else if (ctrl.push_back && is_free_slot) begin
      value <= data_value;
    end else if (ctrl.pop_front) begin
      value <= right_value;
    end
  end

  always_ff @(posedge clk) begin
    hit  <= ctrl.search && valid && (value == data_value);
    pick <= (ctrl.pop_back && is_tail) ? value : '0;
  end

endmodule

### hw/rtl/dqs_reduce.sv
// Collects the per-cell search hits and the popped tail value into one result.
module dqs_reduce #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
  input  logic [DEPTH-1:0]           hit_vec,
  input  logic [dqs_pkg::DATA_W-1:0] pick_arr [DEPTH],
  output logic                       any_hit,
  output logic [dqs_pkg::DATA_W-1:0] picked
);
  import dqs_pkg::*;

  assign any_hit = |hit_vec;

  // At most one cell holds a non-zero pick, so an OR selects it.
  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | pick_arr[i];
    end
  end

endmodule

### hw/rtl/deque_with_search_unit.sv
// Top level of the deque with search: a shifting chain of cells with front and back access.
//
//   channel | role   | carries
//   cmd     | sink   | kind, data_value
//   res     | source | popped_value, entry_count, found, status
//
// Push front, push back, pop front, count, and a pop back or search on an empty deque fill
// the result register directly; pop back and search on a non-empty deque pass through ST_REDUCE:
// each cell registers its compare or tail select, then one OR reduction over all cells fills
// the result register. Reset clears the valid bit of every cell and the count; no item is
// taken while reset is high.
// A new item is taken while the result register is empty or its item is being taken, and
// no pop back or search is in progress in ST_REDUCE.
module deque_with_search_unit #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  dqs_in_if.sink   cmd,
  dqs_out_if.source res
);
  import dqs_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   held_count, count_next;
  logic               out_valid, out_valid_next;
  logic [DATA_W-1:0]  out_popped, out_popped_next;
  logic [CNT_W-1:0]   out_count, out_count_next;
  logic               out_found, out_found_next;
  status_t            out_status, out_status_next;

  logic [DEPTH-1:0]   valid_vec;
  logic [DEPTH-1:0]   hit_vec;
  logic [DATA_W-1:0]  val_arr  [DEPTH];
  logic [DATA_W-1:0]  pick_arr [DEPTH];
  logic               any_hit;
  logic [DATA_W-1:0]  picked;

  logic               accept;
  logic               full;
  logic               empty;
  kind_t              kind_in;
  cell_ctrl_t         ctrl;

  assign kind_in   = kind_t'(cmd.kind);
  assign cmd.ready = !rst && (state == ST_RUN) && (!out_valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (held_count == CNT_W'(DEPTH));
  assign empty     = (held_count == '0);

  always_comb begin
    ctrl            = '0;
    ctrl.push_front = accept && (kind_in == KIND_PUSH_FRONT) && !full;
    ctrl.push_back  = accept && (kind_in == KIND_PUSH_BACK) && !full;
    ctrl.pop_front  = accept && (kind_in == KIND_POP_FRONT) && !empty;
    ctrl.pop_back   = accept && (kind_in == KIND_POP_BACK) && !empty;
    ctrl.search     = accept && (kind_in == KIND_SEARCH) && !empty;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_value;
    logic              left_valid;
    logic [DATA_W-1:0] right_value;
    logic              right_valid;

    // The front cell's left neighbour is the incoming value, always present.
    if (i == 0) begin : g_first
      assign left_value = cmd.data_value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_value = val_arr[i-1];
      assign left_valid = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_value = val_arr[i+1];
      assign right_valid = valid_vec[i+1];
    end

    dqs_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .data_value  (cmd.data_value),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (val_arr[i]),
      .valid       (valid_vec[i]),
      .hit         (hit_vec[i]),
      .pick        (pick_arr[i])
    );
  end

  dqs_reduce #(.DEPTH(DEPTH)) u_reduce (
    .hit_vec  (hit_vec),
    .pick_arr (pick_arr),
    .any_hit  (any_hit),
    .picked   (picked)
  );

  always_comb begin
    state_next      = state;
    count_next      = held_count;
    out_valid_next  = out_valid && !res.ready;
    out_popped_next = out_popped;
    out_count_next  = out_count;
    out_found_next  = out_found;
    out_status_next = out_status;

    case (state)
      ST_RUN: begin
        if (accept) begin
          out_valid_next  = 1'b1;
          out_popped_next = '0;
          out_found_next  = 1'b0;
          out_status_next = STATUS_OK;
          case (kind_in)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              if (full) begin
                out_status_next = STATUS_FULL;
              end else begin
                count_next = held_count + 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              if (empty) begin
                out_status_next = STATUS_EMPTY;
              end else begin
                out_popped_next = val_arr[0];
                count_next      = held_count - 1'b1;
              end
            end
            KIND_POP_BACK: begin
              if (empty) begin
                out_status_next = STATUS_EMPTY;
              end else begin
                count_next     = held_count - 1'b1;
                out_valid_next = 1'b0;
                state_next     = ST_REDUCE;
              end
            end
            KIND_SEARCH: begin
              if (empty) begin
                out_status_next = STATUS_EMPTY;
              end else begin
                out_valid_next = 1'b0;
                state_next     = ST_REDUCE;
              end
            end
            default: begin
            end
          endcase
          out_count_next = count_next;
        end
      end
      ST_REDUCE: begin
        // Cells not involved register zero picks and no hits, so both fields come straight out.
        out_valid_next  = 1'b1;
        out_popped_next = picked;
        out_found_next  = any_hit;
        out_status_next = STATUS_OK;
        out_count_next  = held_count;
        state_next      = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_popped <= out_popped_next;
    out_count  <= out_count_next;
    out_found  <= out_found_next;
    out_status <= out_status_next;
  end

  assign res.valid        = out_valid;
  assign res.popped_value = out_popped;
  assign res.entry_count  = out_count;
  assign res.found        = out_found;
  assign res.status       = out_status;

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(held_count))
    else $error("held count differs from the number of occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied cells are not packed from the front");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(DEPTH))
    else $error("held count exceeds the depth");

  a_reduce_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_REDUCE |-> !out_valid)
    else $error("result register occupied while a two-cycle item completes");

endmodule
